// File: hdl/tpad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpad_pkg;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int WL_IDX_W    = 2;
   localparam int GAIN_W      = 16;
   localparam int AMP_W       = 28;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Datapath widths
   localparam int SQ_W        = 2 * SAMPLE_W;     // one squared difference
   localparam int RAD_W       = SQ_W + 2;         // sum of three squares
   localparam int ROOT_W      = RAD_W / 2;        // floor square root
   localparam int REM_W       = ROOT_W + 3;       // root remainder
   localparam int ISQRT_STEPS = ROOT_W;           // one root bit per stage
   localparam int K_W         = 15;
   localparam int SCALED_W    = ROOT_W + K_W;
   localparam int PROD_W      = SCALED_W + GAIN_W;
   localparam int FRAC_DROP   = PROD_W - AMP_W;   // Q.28 product down to Q.8

   // sqrt(2)/3 in Q0.16
   localparam logic [K_W-1:0]    K_SQRT2_OVER_3 = 15'd30894;
   localparam logic [PROD_W-1:0] ROUND_HALF     = PROD_W'(1) << (FRAC_DROP - 1);

   // Gain registers: 1.0 in Q4.12 after reset, index of wavelength 0
   localparam logic [GAIN_W-1:0]      GAIN_RESET    = 16'd4096;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_BASE = 2'd0;

   typedef struct packed {
      logic                valid;
      logic [WL_IDX_W-1:0] wavelength;
   } tpad_tag_type;

endpackage

`default_nettype wire

// File: hdl/tpad_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpad_req_if import tpad_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_phase_0;
   logic [SAMPLE_W-1:0] sample_phase_120;
   logic [SAMPLE_W-1:0] sample_phase_240;
   logic [WL_IDX_W-1:0] wavelength_index;

   modport source (
      output valid, sample_phase_0, sample_phase_120, sample_phase_240, wavelength_index,
      input  ready
   );
   modport sink (
      input  valid, sample_phase_0, sample_phase_120, sample_phase_240, wavelength_index,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/tpad_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpad_rsp_if import tpad_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [AMP_W-1:0]    ac_amplitude;
   logic [WL_IDX_W-1:0] wavelength_tag;

   modport source (
      output valid, ac_amplitude, wavelength_tag,
      input  ready
   );
   modport sink (
      input  valid, ac_amplitude, wavelength_tag,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/tpad_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpad_csr_if import tpad_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/tpad_sqdiff.sv
`timescale 1ns / 1ps
`default_nettype none

// Three stages: absolute differences, squares, sum.
module tpad_sqdiff import tpad_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic [SAMPLE_W-1:0] sample_a,
   input  logic [SAMPLE_W-1:0] sample_b,
   input  logic [SAMPLE_W-1:0] sample_c,
   input  tpad_tag_type        tag_up,
   output logic [RAD_W-1:0]    sum,
   output tpad_tag_type        tag_dn
);

   logic [SAMPLE_W-1:0] diff_ab_in, diff_ac_in, diff_bc_in;
   logic [SAMPLE_W-1:0] diff_ab_ff, diff_ac_ff, diff_bc_ff;
   logic [SQ_W-1:0]     sq_ab_ff, sq_ac_ff, sq_bc_ff;
   logic [RAD_W-1:0]    sum_in, sum_ff;
   tpad_tag_type        tag1_ff, tag2_ff, tag3_ff;

   always_comb begin
      diff_ab_in = (sample_a >= sample_b) ? sample_a - sample_b : sample_b - sample_a;
      diff_ac_in = (sample_a >= sample_c) ? sample_a - sample_c : sample_c - sample_a;
      diff_bc_in = (sample_b >= sample_c) ? sample_b - sample_c : sample_c - sample_b;
      sum_in     = RAD_W'(sq_ab_ff) + RAD_W'(sq_ac_ff) + RAD_W'(sq_bc_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ab_ff <= diff_ab_in;
         diff_ac_ff <= diff_ac_in;
         diff_bc_ff <= diff_bc_in;
         sq_ab_ff   <= SQ_W'(diff_ab_ff) * SQ_W'(diff_ab_ff);
         sq_ac_ff   <= SQ_W'(diff_ac_ff) * SQ_W'(diff_ac_ff);
         sq_bc_ff   <= SQ_W'(diff_bc_ff) * SQ_W'(diff_bc_ff);
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else if (enable) begin
         tag1_ff <= tag_up;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign sum    = sum_ff;
   assign tag_dn = tag3_ff;

endmodule

`default_nettype wire

// File: hdl/tpad_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Floor square root, restoring digit recurrence, one root bit per stage.
module tpad_isqrt import tpad_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [RAD_W-1:0]  radicand,
   input  tpad_tag_type      tag_up,
   output logic [ROOT_W-1:0] root,
   output tpad_tag_type      tag_dn
);

   logic [REM_W-1:0]       rem_ff  [ISQRT_STEPS];
   logic [ROOT_W-1:0]      root_ff [ISQRT_STEPS];
   logic [RAD_W-1:0]       rad_ff  [ISQRT_STEPS];
   tpad_tag_type           tag_ff  [ISQRT_STEPS];
   logic [ISQRT_STEPS-1:0] valid_vec;

   genvar k;
   for (k = 0; k < ISQRT_STEPS; k++) begin : g_step
      logic [REM_W-1:0]  rem_prev, rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [RAD_W-1:0]  rad_prev, rad_in;
      tpad_tag_type      tag_prev;
      logic              fits;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
         assign tag_prev  = tag_up;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign tag_prev  = tag_ff[k-1];
      end

      // bring down two radicand bits, try (4*root + 1)
      always_comb begin
         rem_sh  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial   = REM_W'({root_prev, 2'b01});
         fits    = (rem_sh >= trial);
         rem_in  = fits ? rem_sh - trial : rem_sh;
         root_in = {root_prev[ROOT_W-2:0], fits};
         rad_in  = {rad_prev[RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (enable) begin
            tag_ff[k] <= tag_prev;
         end
      end

      assign valid_vec[k] = tag_ff[k].valid;
   end

   assign root   = root_ff[ISQRT_STEPS-1];
   assign tag_dn = tag_ff[ISQRT_STEPS-1];

`ifndef SYNTH
   // a held pipeline must neither drop nor create items
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(valid_vec))
      else $error("isqrt valid bits changed while stalled");

   // floor root: final remainder never exceeds 2*root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      tag_ff[ISQRT_STEPS-1].valid |->
         (rem_ff[ISQRT_STEPS-1] <= REM_W'({root_ff[ISQRT_STEPS-1], 1'b0})))
      else $error("isqrt remainder out of range");
`endif

endmodule

`default_nettype wire

// File: hdl/tpad_scale.sv
`timescale 1ns / 1ps
`default_nettype none

// Three stages: root * sqrt(2)/3, times gain, round to Q20.8.
module tpad_scale import tpad_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [ROOT_W-1:0] root,
   input  logic [GAIN_W-1:0] gain,
   input  tpad_tag_type      tag_up,
   output logic [AMP_W-1:0]  amplitude,
   output tpad_tag_type      tag_dn
);

   logic [SCALED_W-1:0] scaled_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   rounded_in;
   logic [AMP_W-1:0]    amp_ff;
   tpad_tag_type        tag1_ff, tag2_ff, tag3_ff;

   assign rounded_in = prod_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (enable) begin
         scaled_ff <= SCALED_W'(root) * SCALED_W'(K_SQRT2_OVER_3);
         gain_ff   <= gain;
         prod_ff   <= PROD_W'(scaled_ff) * PROD_W'(gain_ff);
         amp_ff    <= rounded_in[FRAC_DROP +: AMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else if (enable) begin
         tag1_ff <= tag_up;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign amplitude = amp_ff;
   assign tag_dn    = tag3_ff;

endmodule

`default_nettype wire

// File: hdl/three_phase_ac_demodulation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-phase AC amplitude demodulator.
// req_chan: one request per pixel: three 16-bit samples (0/120/240 degrees)
//    and a 2-bit wavelength index. Taken when valid and ready are both high.
// rsp_chan: one response per request, in order: ac_amplitude (Q20.8) and
//    wavelength_tag. A wavelength at or above WAVELENGTHS yields amplitude 0.
// csr_chan: gain writes, index 0..3 selects the wavelength, data is Q4.12.
//    Always ready; write only while no request is in flight.
// Pipeline: 3 square/sum stages, 17 square-root stages at one root bit
//    each, 3 scaling stages.
// Throughput: one request per cycle unless stalled; the 17 root stages make up most of the depth.
// Stall: when a response sits unaccepted the whole pipeline freezes and
//    req_chan.ready drops in the same cycle; nothing is lost or repeated.
// Reset: clears all valid bits and sets every gain to 1.0 (4096).
module three_phase_ac_demodulation_core import tpad_pkg::*; #(
   parameter int WAVELENGTHS = 4
) (
   input  logic        clock,
   input  logic        reset,
   tpad_req_if.sink    req_chan,
   tpad_rsp_if.source  rsp_chan,
   tpad_csr_if.sink    csr_chan
);

   logic              advance;
   tpad_tag_type      entry_tag, sum_tag, root_tag, out_tag;
   logic [RAD_W-1:0]  sum;
   logic [ROOT_W-1:0] root;
   logic [GAIN_W-1:0] gain_sel;
   logic [AMP_W-1:0]  amplitude;
   logic [GAIN_W-1:0] gain_ff [WAVELENGTHS];

   // Global pipeline enable: move whenever the output register is empty or its response is taken.
   assign advance        = !out_tag.valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   assign entry_tag.valid      = req_chan.valid;
   assign entry_tag.wavelength = req_chan.wavelength_index;

   // Gain registers, one per wavelength.
   genvar i;
   for (i = 0; i < WAVELENGTHS; i++) begin : g_gain
      always_ff @(posedge clock) begin
         if (reset) begin
            gain_ff[i] <= GAIN_RESET;
         end else if (csr_chan.valid &&
                      csr_chan.index == CSR_INDEX_W'(int'(CSR_GAIN_BASE) + i)) begin
            gain_ff[i] <= csr_chan.data;
         end
      end
   end

   // Gain lookup next to the scaler; unused wavelengths get zero gain.
   always_comb begin
      gain_sel = '0;
      for (int w = 0; w < WAVELENGTHS; w++) begin
         if (root_tag.wavelength == WL_IDX_W'(w)) begin
            gain_sel = gain_ff[w];
         end
      end
   end

   tpad_sqdiff u_sqdiff (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .sample_a (req_chan.sample_phase_0),
      .sample_b (req_chan.sample_phase_120),
      .sample_c (req_chan.sample_phase_240),
      .tag_up   (entry_tag),
      .sum      (sum),
      .tag_dn   (sum_tag)
   );

   tpad_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .radicand (sum),
      .tag_up   (sum_tag),
      .root     (root),
      .tag_dn   (root_tag)
   );

   tpad_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .root      (root),
      .gain      (gain_sel),
      .tag_up    (root_tag),
      .amplitude (amplitude),
      .tag_dn    (out_tag)
   );

   assign rsp_chan.valid          = out_tag.valid;
   assign rsp_chan.ac_amplitude   = amplitude;
   assign rsp_chan.wavelength_tag = out_tag.wavelength;

`ifndef SYNTH
   a_unused_wl_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (int'(rsp_chan.wavelength_tag) >= WAVELENGTHS)) |->
         (rsp_chan.ac_amplitude == '0))
      else $error("nonzero amplitude for unused wavelength");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

// File: bench/tpad_demod_checker.sv
`timescale 1ns / 1ps

module tpad_demod_checker import tpad_pkg::*; #(
   parameter int WAVELENGTHS = 4
) (
   input  logic clock,
   input  logic reset,
   tpad_req_if  req_mon,
   tpad_rsp_if  rsp_mon,
   tpad_csr_if  csr_mon,
   output int   mismatch_count,
   output int   outstanding
);

   localparam int unsigned     ROOT2_THIRD_Q16 = 30894;  // sqrt(2)/3, Q0.16
   localparam logic [GAIN_W-1:0] UNITY_GAIN    = 16'd4096; // 1.0 in Q4.12
   localparam int              GAIN_SLOTS      = 2 ** CSR_INDEX_W;
   localparam int              REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [AMP_W-1:0]    amplitude;
      logic [WL_IDX_W-1:0] wavelength;
   } amplitude_result_t;

   logic [GAIN_W-1:0] gain_shadow [GAIN_SLOTS];
   amplitude_result_t expected_amplitudes [$];
   int                errors = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic logic [SQ_W+1:0] squared_gap(input logic [SAMPLE_W-1:0] x,
                                                   input logic [SAMPLE_W-1:0] y);
      logic [SAMPLE_W-1:0] d;
      d = (x >= y) ? x - y : y - x;
      return (SQ_W+2)'(d) * (SQ_W+2)'(d);
   endfunction

   // floor square root, one root bit at a time from the top
   function automatic logic [16:0] floor_root(input logic [SQ_W+1:0] radicand);
      logic [16:0] root;
      logic [16:0] trial;
      root = '0;
      for (int k = 16; k >= 0; k--) begin
         trial = root | (17'd1 << k);
         if (64'(trial) * 64'(trial) <= 64'(radicand))
            root = trial;
      end
      return root;
   endfunction

   function automatic amplitude_result_t demodulate(input logic [SAMPLE_W-1:0] p0,
                                                    input logic [SAMPLE_W-1:0] p120,
                                                    input logic [SAMPLE_W-1:0] p240,
                                                    input logic [WL_IDX_W-1:0] wl);
      amplitude_result_t res;
      logic [SQ_W+1:0]   radicand;
      logic [GAIN_W-1:0] gain;
      logic [63:0]       product;
      logic [63:0]       rounded;
      radicand = squared_gap(p0, p120) + squared_gap(p0, p240) + squared_gap(p120, p240);
      gain     = (int'(wl) < WAVELENGTHS) ? gain_shadow[wl] : '0;
      // root * Q0.16 * Q4.12 leaves 28 fraction bits; keep 8, round half up
      product  = 64'(floor_root(radicand)) * 64'(ROOT2_THIRD_Q16) * 64'(gain);
      rounded  = (product + (64'd1 << 19)) >> 20;
      res.amplitude  = ((rounded >> AMP_W) != 0) ? '1 : rounded[AMP_W-1:0];
      res.wavelength = wl;
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (errors < REPORT_LIMIT)
         $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want_v, got_v);
      errors++;
   endtask

   always @(posedge clock) begin
      amplitude_result_t want;
      if (reset) begin
         foreach (gain_shadow[i]) gain_shadow[i] = UNITY_GAIN;
         expected_amplitudes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_amplitudes.size() == 0) begin
               note_mismatch("response with no request pending", 0, rsp_mon.ac_amplitude);
            end else begin
               want = expected_amplitudes.pop_front();
               if (rsp_mon.ac_amplitude !== want.amplitude)
                  note_mismatch("ac_amplitude", want.amplitude, rsp_mon.ac_amplitude);
               if (rsp_mon.wavelength_tag !== want.wavelength)
                  note_mismatch("wavelength_tag", want.wavelength, rsp_mon.wavelength_tag);
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            gain_shadow[csr_mon.index] = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            expected_amplitudes.push_back(demodulate(req_mon.sample_phase_0,
                                                     req_mon.sample_phase_120,
                                                     req_mon.sample_phase_240,
                                                     req_mon.wavelength_index));
      end
      mismatch_count <= errors;
      outstanding    <= expected_amplitudes.size();
   end

endmodule

// File: bench/three_phase_ac_demodulation_core_test.sv
`timescale 1ns / 1ps

module three_phase_ac_demodulation_core_test;
   import tpad_pkg::*;

   localparam int WAVELENGTHS       = 4;
   localparam int RANDOM_PHASES     = 5;
   localparam int PHASE_PIXELS      = 220;
   localparam int LONG_STALL_CYCLES = 400;  // far deeper than the 23-stage pipe
   localparam int SETTLE_CYCLES     = 30;   // a bit over the request-to-response latency

   typedef struct packed {
      logic [SAMPLE_W-1:0] p0;
      logic [SAMPLE_W-1:0] p120;
      logic [SAMPLE_W-1:0] p240;
      logic [WL_IDX_W-1:0] wl;
   } pixel_t;

   logic clock;
   logic reset;
   logic long_stall;
   int   mismatch_count;
   int   outstanding;
   int   burst_left = 0;
   event long_stall_go;

   tpad_req_if req_chan ();
   tpad_rsp_if rsp_chan ();
   tpad_csr_if csr_chan ();

   three_phase_ac_demodulation_core #(
      .WAVELENGTHS (WAVELENGTHS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // watches all three channels, predicts each response and compares
   tpad_demod_checker #(
      .WAVELENGTHS (WAVELENGTHS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // hard stop in case the handshakes hang
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   // Long response hold-off. Counted here so the sender keeps pushing requests
   // meanwhile: the pipe fills up and req_chan.ready has to drop.
   initial begin
      long_stall = 1'b0;
      forever begin
         @(long_stall_go);
         long_stall <= 1'b1;
         repeat (LONG_STALL_CYCLES) @(posedge clock);
         long_stall <= 1'b0;
      end
   end

   // Response side: ready follows a duty cycle that is redrawn at random,
   // including stretches at 100 percent where it never stalls.
   initial begin
      int ready_pct;
      int span;
      rsp_chan.ready = 1'b0;
      ready_pct      = 100;
      span           = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            case ($urandom_range(0, 4))
               0, 1: ready_pct = 100;
               2: ready_pct = 70;
               3: ready_pct = 40;
               default: ready_pct = 15;
            endcase
            span = $urandom_range(20, 300);
         end
         span--;
         rsp_chan.ready <= !long_stall && ($urandom_range(1, 100) <= ready_pct);
      end
   end

   function automatic pixel_t pixel(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                                    input logic [SAMPLE_W-1:0] c, input logic [WL_IDX_W-1:0] w);
      return '{a, b, c, w};
   endfunction

   // level plus a small random offset, clamped to the sample range
   function automatic logic [SAMPLE_W-1:0] nudge(input logic [SAMPLE_W-1:0] level,
                                                 input int spread);
      int v;
      v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)
         v = 0;
      else if (v > 65535)
         v = 65535;
      return SAMPLE_W'(v);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rail_value();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic pixel_t random_pixel();
      pixel_t              px;
      logic [SAMPLE_W-1:0] level;
      int                  spread;
      level  = SAMPLE_W'($urandom);
      spread = $urandom_range(1, 300);
      px     = pixel(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     WL_IDX_W'($urandom_range(0, 3)));
      case ($urandom_range(0, 7))
         0: begin  // flat pixel, no modulation at all
            px.p0 = level; px.p120 = level; px.p240 = level;
         end
         1, 2: begin  // weak modulation on a bright or dark background
            px.p0 = nudge(level, spread); px.p120 = nudge(level, spread);
            px.p240 = nudge(level, spread);
         end
         3: begin  // only one phase differs
            px.p0 = level; px.p120 = level;
         end
         4: begin  // saturated or black samples mixed in
            px.p0 = rail_value(); px.p120 = rail_value(); px.p240 = rail_value();
         end
         default: ;
      endcase
      return px;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return GAIN_W'(1);
         3: return 16'd4096;  // unity
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // Offers one request. The sender runs in bursts; between bursts valid may drop
   // for a random gap with junk on the data lines. valid stays high from one
   // request to the next inside a burst.
   task automatic send_pixel(input pixel_t px);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0: begin gap = 0; burst_left = $urandom_range(60, 150); end
            1, 2, 3: begin gap = $urandom_range(1, 4); burst_left = $urandom_range(1, 20); end
            4: begin gap = $urandom_range(5, 30); burst_left = $urandom_range(1, 20); end
            default: begin gap = 0; burst_left = $urandom_range(1, 8); end
         endcase
         if (gap > 0) begin
            req_chan.valid            <= 1'b0;
            req_chan.sample_phase_0   <= SAMPLE_W'($urandom);
            req_chan.sample_phase_120 <= SAMPLE_W'($urandom);
            req_chan.sample_phase_240 <= SAMPLE_W'($urandom);
            req_chan.wavelength_index <= WL_IDX_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid            <= 1'b1;
      req_chan.sample_phase_0   <= px.p0;
      req_chan.sample_phase_120 <= px.p120;
      req_chan.sample_phase_240 <= px.p240;
      req_chan.wavelength_index <= px.wl;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop offering and wait until every predicted response has come back.
   // Every request yields a response, so an empty queue means an idle pipe.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Writes all four gains back to back; call only when idle.
   task automatic set_gains(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                            input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3);
      logic [GAIN_W-1:0] gains [4];
      gains = '{g0, g1, g2, g3};
      for (int w = 0; w < 4; w++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= CSR_GAIN_BASE + CSR_INDEX_W'(w);
         csr_chan.data  <= gains[w];
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.sample_phase_0   = '0;
      req_chan.sample_phase_120 = '0;
      req_chan.sample_phase_240 = '0;
      req_chan.wavelength_index = '0;
      csr_chan.valid            = 1'b0;
      csr_chan.index            = '0;
      csr_chan.data             = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed, gains still at their reset value of 1.0
      send_pixel(pixel(16'h0000, 16'h0000, 16'h0000, 2'd0));  // all dark
      send_pixel(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd1));  // all saturated, no AC
      send_pixel(pixel(16'hFFFF, 16'h0000, 16'h0000, 2'd2));  // largest sum of squares
      send_pixel(pixel(16'h0000, 16'hFFFF, 16'hFFFF, 2'd3));
      send_pixel(pixel(16'h0000, 16'h8000, 16'hFFFF, 2'd0));
      send_pixel(pixel(16'h0001, 16'h0000, 16'h0000, 2'd1));  // smallest nonzero swing
      send_pixel(pixel(16'hAAAA, 16'h5555, 16'hFFFF, 2'd2));
      send_pixel(pixel(16'h5555, 16'hAAAA, 16'h0000, 2'd3));
      send_pixel(pixel(16'h3039, 16'h303A, 16'h3038, 2'd0));
      wait_idle();

      // Directed with extreme gains: full scale, zero, the smallest step, 8.0
      set_gains(16'hFFFF, 16'h0000, 16'h0001, 16'h8000);
      send_pixel(pixel(16'hFFFF, 16'h0000, 16'h0000, 2'd0));  // largest amplitude overall
      send_pixel(pixel(16'h0000, 16'hFFFF, 16'h0000, 2'd0));
      send_pixel(pixel(16'hFFFF, 16'h0000, 16'h0000, 2'd1));  // zero gain gives zero
      send_pixel(pixel(16'hFFFF, 16'h0000, 16'h0000, 2'd2));  // tiny gain, rounding
      send_pixel(pixel(16'h0003, 16'h0000, 16'h0000, 2'd2));
      send_pixel(pixel(16'hFFFF, 16'h0000, 16'hFFFF, 2'd3));
      send_pixel(pixel(16'h0000, 16'h0000, 16'hFFFF, 2'd3));

      // Random phases, each with its own gain set
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if ((phase == 1 && n == 30) || (phase == 3 && n == 100))
               -> long_stall_go;
            // one full drain in the middle of a phase
            if (phase == 2 && n == 110)
               wait_idle();
            send_pixel(random_pixel());
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
